// File: hw/rtl/imuf_pkg.sv
// Shared types and constants of the IMU serial frame parser.
package imuf_pkg;

   localparam logic [7:0] HDR_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_ACC  = 8'h51;
   localparam logic [7:0] TYPE_RATE = 8'h52;
   localparam logic [7:0] TYPE_ANG  = 8'h53;

   // byte positions: 0 = hunting, 1..9 = collecting, 10 = checksum byte next
   localparam logic [3:0] POS_LAST = 4'd10;
   // frame bytes 1..7 (type and three values) are the only ones kept
   localparam int STORE_DEPTH = 7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30;

   typedef enum logic [2:0] {
      STAT_CSUM_ERR = 3'd0,
      STAT_ACC      = 3'd1,
      STAT_RATE     = 3'd2,
      STAT_ANG      = 3'd3,
      STAT_OTHER    = 3'd4
   } frame_status_type;

   typedef struct packed {
      frame_status_type   frame_status;
      logic signed [15:0] roll_raw;
      logic signed [15:0] pitch_raw;
      logic signed [15:0] yaw_raw;
      logic signed [15:0] rate_x_raw;
      logic signed [15:0] rate_y_raw;
      logic signed [15:0] rate_z_raw;
      logic signed [15:0] acc_x_raw;
      logic signed [15:0] acc_y_raw;
      logic signed [15:0] acc_z_raw;
      logic [31:0]        sample_time_ms;
      logic [31:0]        sample_count;
   } imuf_rsp_type;

endpackage

// File: hw/rtl/imu_uart_frame_parser.sv
// Top level of the IMU serial frame parser: stream ports, timeout register, word registers.
// Takes one received byte per word with its millisecond time, hunts for the 0x55 header,
// collects 11-byte frames and checks the 8-bit sum checksum; each finished frame yields one
// result word with a status code and the latched accel, rate and angle values (raw signed
// 16-bit), plus the time and count of angle samples. One byte is taken every cycle unless a
// checksum byte waits on a stalled result word; a result word is built from the checksum byte
// in the input register and held in the result register, and the checksum is kept as a running
// sum so each byte finishes in one pass. A partial frame is dropped once more than the timeout
// register's milliseconds have passed since its header.
module imu_uart_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // rx_byte[7:0], now_ms[39:8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // frame_status[2:0], roll_raw[18:3], pitch_raw[34:19], yaw_raw[50:35],
   // rate_x_raw[66:51], rate_y_raw[82:67], rate_z_raw[98:83], acc_x_raw[114:99],
   // acc_y_raw[130:115], acc_z_raw[146:131], sample_time_ms[178:147],
   // sample_count[210:179], zero[215:211]
   output logic [215:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data     // frame_timeout_ms
);
   import imuf_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic [31:0] in_now_ff, in_now_in;
   logic        out_vld_ff, out_vld_in;
   imuf_rsp_type out_ff, out_in;
   logic [15:0] timeout_ff, timeout_in;

   logic         req_acc;
   logic         out_free;
   logic         proc_go;
   logic         has_rsp;
   imuf_rsp_type rsp_next;

   imuf_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .go         (proc_go),
      .rx_byte    (in_byte_ff),
      .now_ms     (in_now_ff),
      .timeout_ms (timeout_ff),
      .has_rsp    (has_rsp),
      .rsp        (rsp_next)
   );

   assign out_free   = !out_vld_ff || rsp_tready;
   // a byte that ends no frame never waits on the result side
   assign proc_go    = in_vld_ff && (!has_rsp || out_free);
   assign req_tready = !in_vld_ff || proc_go;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      in_now_in  = in_now_ff;
      if (req_acc) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_tdata[7:0];
         in_now_in  = req_tdata[39:8];
      end else if (proc_go) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (proc_go && has_rsp) begin
         out_vld_in = 1'b1;
         out_in     = rsp_next;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end

      timeout_in = timeout_ff;
      if (csr_valid && csr_ready) begin
         timeout_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         timeout_ff <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_now_ff  <= in_now_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0,
                        out_ff.sample_count,
                        out_ff.sample_time_ms,
                        out_ff.acc_z_raw,
                        out_ff.acc_y_raw,
                        out_ff.acc_x_raw,
                        out_ff.rate_z_raw,
                        out_ff.rate_y_raw,
                        out_ff.rate_x_raw,
                        out_ff.yaw_raw,
                        out_ff.pitch_raw,
                        out_ff.roll_raw,
                        out_ff.frame_status};

endmodule

// File: hw/rtl/imuf_parse.sv
// Frame hunting, checksum, timeout and value latches of the IMU frame parser.
module imuf_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           rx_byte,
   input  logic [31:0]          now_ms,
   input  logic [15:0]          timeout_ms,
   output logic                 has_rsp,
   output imuf_pkg::imuf_rsp_type rsp
);
   import imuf_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  frame_ff [STORE_DEPTH];
   logic [7:0]  frame_in [STORE_DEPTH];
   logic [31:0] hdr_time_ff, hdr_time_in;
   logic [15:0] acc_ff [3];
   logic [15:0] acc_in [3];
   logic [15:0] rate_ff [3];
   logic [15:0] rate_in [3];
   logic [15:0] ang_ff [3];
   logic [15:0] ang_in [3];
   logic [31:0] stime_ff, stime_in;
   logic [31:0] scount_ff, scount_in;

   logic [31:0] elapsed;
   logic        expired;
   logic [3:0]  pos_eff;
   logic        is_hdr;
   logic        csum_ok;
   logic [15:0] triplet [3];
   frame_status_type status;

   // elapsed time wraps like the millisecond counter
   assign elapsed = now_ms - hdr_time_ff;
   assign expired = (pos_ff != 4'd0) && (elapsed > {16'd0, timeout_ms});
   assign pos_eff = expired ? 4'd0 : pos_ff;
   assign is_hdr  = (rx_byte == HDR_BYTE);
   assign csum_ok = (sum_ff == rx_byte);
   assign has_rsp = (pos_eff == POS_LAST);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         triplet[k] = {frame_ff[2*k+2], frame_ff[2*k+1]};
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      frame_in    = frame_ff;
      hdr_time_in = hdr_time_ff;
      acc_in      = acc_ff;
      rate_in     = rate_ff;
      ang_in      = ang_ff;
      stime_in    = stime_ff;
      scount_in   = scount_ff;
      status      = STAT_OTHER;

      if (pos_eff == 4'd0) begin
         pos_in = 4'd0;
         if (is_hdr) begin
            pos_in      = 4'd1;
            sum_in      = rx_byte;
            hdr_time_in = now_ms;
         end
      end else if (pos_eff < POS_LAST) begin
         for (int j = 0; j < STORE_DEPTH; j++) begin
            if (pos_eff == 4'(j + 1)) begin
               frame_in[j] = rx_byte;
            end
         end
         sum_in = sum_ff + rx_byte;
         pos_in = pos_eff + 4'd1;
      end else begin
         pos_in = 4'd0;
         if (!csum_ok) begin
            status = STAT_CSUM_ERR;
            // a bad checksum byte that looks like a header opens a new frame
            if (is_hdr) begin
               pos_in      = 4'd1;
               sum_in      = rx_byte;
               hdr_time_in = now_ms;
            end
         end else begin
            case (frame_ff[0])
               TYPE_ACC: begin
                  acc_in = triplet;
                  status = STAT_ACC;
               end
               TYPE_RATE: begin
                  rate_in = triplet;
                  status  = STAT_RATE;
               end
               TYPE_ANG: begin
                  ang_in    = triplet;
                  stime_in  = now_ms;
                  scount_in = scount_ff + 32'd1;
                  status    = STAT_ANG;
               end
               default: begin
                  status = STAT_OTHER;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp.frame_status   = status;
      rsp.roll_raw       = ang_in[0];
      rsp.pitch_raw      = ang_in[1];
      rsp.yaw_raw        = ang_in[2];
      rsp.rate_x_raw     = rate_in[0];
      rsp.rate_y_raw     = rate_in[1];
      rsp.rate_z_raw     = rate_in[2];
      rsp.acc_x_raw      = acc_in[0];
      rsp.acc_y_raw      = acc_in[1];
      rsp.acc_z_raw      = acc_in[2];
      rsp.sample_time_ms = stime_in;
      rsp.sample_count   = scount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 4'd0;
         sum_ff      <= 8'd0;
         hdr_time_ff <= 32'd0;
         acc_ff      <= '{default: 16'd0};
         rate_ff     <= '{default: 16'd0};
         ang_ff      <= '{default: 16'd0};
         stime_ff    <= 32'd0;
         scount_ff   <= 32'd0;
      end else if (go) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         hdr_time_ff <= hdr_time_in;
         acc_ff      <= acc_in;
         rate_ff     <= rate_in;
         ang_ff      <= ang_in;
         stime_ff    <= stime_in;
         scount_ff   <= scount_in;
      end
   end

   // frame bytes are always written before they are read
   always_ff @(posedge clock) begin
      if (go) begin
         frame_ff <= frame_in;
      end
   end

endmodule

// File: hw/rtl/imuf_checker.sv
// Port-level assertions of the IMU frame parser and their bind.
module imuf_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [215:0] rsp_tdata
);
   import imuf_pkg::*;

   logic        rsp_acc;
   logic [31:0] count_ff, count_in;
   logic [2:0]  stat;
   logic [31:0] count;

   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign stat    = rsp_tdata[2:0];
   assign count   = rsp_tdata[210:179];

   assign count_in = rsp_acc ? count : count_ff;

   // sample count seen on the last delivered word
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 32'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (stat <= STAT_OTHER) && (rsp_tdata[215:211] == 5'd0))
      else $error("bad status code or padding");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && (stat != STAT_ANG) |-> count == count_ff)
      else $error("sample count moved without an angle frame");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && (stat == STAT_ANG) |-> count == count_ff + 32'd1)
      else $error("angle frame did not advance sample count by one");

endmodule

bind imu_uart_frame_parser imuf_checker u_imuf_checker (.*);

// File: tb/imuf_frame_checker.sv
// Checker for the IMU frame parser: predicts result words from accepted bytes and compares them.
`timescale 1ns / 1ps

module imuf_frame_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [39:0]  req_tdata,   // rx_byte[7:0], now_ms[39:8]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [215:0] rsp_tdata,   // frame_status[2:0] ... sample_count[210:179]
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,    // frame_timeout_ms
   output int           fail_count,
   output int           in_flight,
   output int           frames_checked
);
   import imuf_pkg::*;

   // parser state as the block should hold it
   logic [15:0]        timeout_ms;
   logic [3:0]         pos;
   logic [7:0]         run_sum;
   logic [7:0]         frame_bytes [10];
   logic [31:0]        hdr_ms;
   logic signed [15:0] acc_q [3];
   logic signed [15:0] rate_q [3];
   logic signed [15:0] ang_q [3];
   logic [31:0]        smp_ms;
   logic [31:0]        smp_cnt;

   imuf_rsp_type expected_frames [$];
   imuf_rsp_type want;

   task automatic open_frame(input logic [7:0] b, input logic [31:0] t);
      frame_bytes[0] = b;
      run_sum = b;
      pos = 4'd1;
      hdr_ms = t;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic [31:0] t);
      logic [31:0]      elapsed;
      frame_status_type st;
      imuf_rsp_type     r;
      elapsed = t - hdr_ms;
      // a stale partial frame is dropped before this byte is looked at
      if (pos != 4'd0 && elapsed > {16'd0, timeout_ms})
         pos = 4'd0;
      if (pos == 4'd0) begin
         if (b == HDR_BYTE)
            open_frame(b, t);
      end else if (pos < POS_LAST) begin
         frame_bytes[pos] = b;
         run_sum = run_sum + b;
         pos = pos + 4'd1;
      end else begin
         pos = 4'd0;
         if (run_sum != b) begin
            st = STAT_CSUM_ERR;
            if (b == HDR_BYTE)
               open_frame(b, t);
         end else begin
            case (frame_bytes[1])
               TYPE_ACC: begin
                  for (int k = 0; k < 3; k++)
                     acc_q[k] = {frame_bytes[3 + 2 * k], frame_bytes[2 + 2 * k]};
                  st = STAT_ACC;
               end
               TYPE_RATE: begin
                  for (int k = 0; k < 3; k++)
                     rate_q[k] = {frame_bytes[3 + 2 * k], frame_bytes[2 + 2 * k]};
                  st = STAT_RATE;
               end
               TYPE_ANG: begin
                  for (int k = 0; k < 3; k++)
                     ang_q[k] = {frame_bytes[3 + 2 * k], frame_bytes[2 + 2 * k]};
                  smp_ms = t;
                  smp_cnt = smp_cnt + 32'd1;
                  st = STAT_ANG;
               end
               default: st = STAT_OTHER;
            endcase
         end
         r.frame_status   = st;
         r.roll_raw       = ang_q[0];
         r.pitch_raw      = ang_q[1];
         r.yaw_raw        = ang_q[2];
         r.rate_x_raw     = rate_q[0];
         r.rate_y_raw     = rate_q[1];
         r.rate_z_raw     = rate_q[2];
         r.acc_x_raw      = acc_q[0];
         r.acc_y_raw      = acc_q[1];
         r.acc_z_raw      = acc_q[2];
         r.sample_time_ms = smp_ms;
         r.sample_count   = smp_cnt;
         expected_frames.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timeout_ms = TIMEOUT_RESET;
         pos = 4'd0;
         run_sum = 8'd0;
         hdr_ms = 32'd0;
         for (int k = 0; k < 10; k++)
            frame_bytes[k] = 8'd0;
         for (int k = 0; k < 3; k++) begin
            acc_q[k] = 16'sd0;
            rate_q[k] = 16'sd0;
            ang_q[k] = 16'sd0;
         end
         smp_ms = 32'd0;
         smp_cnt = 32'd0;
         expected_frames.delete();
         fail_count = 0;
         frames_checked = 0;
         in_flight = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: result word with no frame pending, expected none, actual %0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_status", 32'(want.frame_status), 32'(rsp_tdata[2:0]));
               check_field("roll_raw", $unsigned(want.roll_raw), rsp_tdata[18:3]);
               check_field("pitch_raw", $unsigned(want.pitch_raw), rsp_tdata[34:19]);
               check_field("yaw_raw", $unsigned(want.yaw_raw), rsp_tdata[50:35]);
               check_field("rate_x_raw", $unsigned(want.rate_x_raw), rsp_tdata[66:51]);
               check_field("rate_y_raw", $unsigned(want.rate_y_raw), rsp_tdata[82:67]);
               check_field("rate_z_raw", $unsigned(want.rate_z_raw), rsp_tdata[98:83]);
               check_field("acc_x_raw", $unsigned(want.acc_x_raw), rsp_tdata[114:99]);
               check_field("acc_y_raw", $unsigned(want.acc_y_raw), rsp_tdata[130:115]);
               check_field("acc_z_raw", $unsigned(want.acc_z_raw), rsp_tdata[146:131]);
               check_field("sample_time_ms", want.sample_time_ms, rsp_tdata[178:147]);
               check_field("sample_count", want.sample_count, rsp_tdata[210:179]);
               frames_checked++;
            end
         end
         if (csr_valid && csr_ready)
            timeout_ms = csr_data;
         if (req_tvalid && req_tready)
            parse_byte(req_tdata[7:0], req_tdata[39:8]);
         in_flight = expected_frames.size();
      end
   end

endmodule

// File: tb/tb.sv
// Testbench top for the IMU frame parser: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module tb;
   import imuf_pkg::*;

   typedef logic [7:0] frame_bytes_type [11];

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;   // rx_byte[7:0], now_ms[39:8]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [215:0] rsp_tdata;   // frame_status[2:0] ... sample_count[210:179], zero[215:211]
   logic         csr_valid;
   logic         csr_ready;
   logic [15:0]  csr_data;    // frame_timeout_ms

   int fail_count;
   int in_flight;
   int frames_checked;

   logic [31:0] now_ms;
   logic [15:0] cur_timeout;
   bit          idle_on;
   bit          stall_on = 1'b0;
   int          stall_left = 0;
   int          bytes_sent;
   int          settings;

   imu_uart_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   imuf_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .in_flight      (in_flight),
      .frames_checked (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result-side backpressure in random bursts
   always @(negedge clock) begin
      if (!stall_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("Run stopped at %0t: results did not drain", $time);
      $display("*** FAILED ***");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the handshake
   task automatic put_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now_ms, b};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_timeout = v;
      settings++;
   endtask

   function automatic logic [7:0] frame_sum(input frame_bytes_type fb);
      logic [7:0] s;
      s = 8'd0;
      for (int i = 0; i < 10; i++)
         s = s + fb[i];
      return s;
   endfunction

   function automatic logic [15:0] pick_value();
      if ($urandom_range(0, 7) != 0)
         return 16'($urandom());
      case ($urandom_range(0, 3))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return 16'h0000;
      endcase
   endfunction

   // sends the first len bytes of a frame; with jitter the clock may jump mid-frame
   task automatic put_frame(input frame_bytes_type fb, input int len, input bit jitter);
      logic [31:0] hdr;
      hdr = now_ms;
      put_byte(fb[0]);
      for (int i = 1; i < len; i++) begin
         if (cur_timeout >= 16'd20)
            now_ms = now_ms + $urandom_range(0, 1);
         if (jitter && $urandom_range(0, 49) == 0) begin
            case ($urandom_range(0, 2))
               0: now_ms = hdr + cur_timeout + $urandom_range(0, 1);  // right at the limit
               1: now_ms = now_ms - $urandom_range(1, 100);         // clock went back
               default: now_ms = $urandom();
            endcase
         end
         put_byte(fb[i]);
      end
   endtask

   task automatic random_chunk(input bit quiet);
      frame_bytes_type fb;
      logic [15:0]  v;
      logic [7:0]   s;
      int           pick;
      pick = $urandom_range(0, 99);
      idle_on = !quiet && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0)
         now_ms = $urandom_range(0, 1) ? $urandom() : 32'hFFFF_FFF0 + $urandom_range(0, 15);
      else
         now_ms = now_ms + $urandom_range(0, 5);
      if (pick < 88) begin
         fb[0] = HDR_BYTE;
         case ($urandom_range(0, 9))
            0, 1, 2: fb[1] = TYPE_ACC;
            3, 4:    fb[1] = TYPE_RATE;
            5, 6, 7: fb[1] = TYPE_ANG;
            default: fb[1] = 8'($urandom());
         endcase
         for (int k = 0; k < 3; k++) begin
            v = pick_value();
            fb[2 + 2 * k] = v[7:0];
            fb[3 + 2 * k] = v[15:8];
         end
         fb[8] = 8'($urandom());
         fb[9] = 8'($urandom());
         s = frame_sum(fb);
         if ($urandom_range(0, 7) != 0)
            fb[10] = s;
         else if ($urandom_range(0, 1) == 1 && s != HDR_BYTE)
            fb[10] = HDR_BYTE;
         else
            fb[10] = s ^ 8'($urandom_range(1, 255));
         put_frame(fb, (pick < 75) ? 11 : $urandom_range(1, 10), 1'b1);
      end else begin
         repeat ($urandom_range(1, 6))
            put_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom()));
      end
   endtask

   initial begin
      frame_bytes_type fb;
      logic [15:0]  phase_timeout [5];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      now_ms = 32'd0;
      cur_timeout = TIMEOUT_RESET;
      idle_on = 1'b1;
      bytes_sent = 0;
      settings = 1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: stray bytes, accel frame at the value extremes, then a bad
      // angle frame whose checksum byte is a header and opens a new frame
      stall_on <= 1'b1;
      put_byte(8'h00);
      put_byte(8'hFF);
      fb = '{8'h55, 8'h51, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
      fb[10] = frame_sum(fb);
      put_frame(fb, 11, 1'b0);
      fb = '{8'h55, 8'h53, 8'h34, 8'h12, 8'hCC, 8'hED, 8'h00, 8'h80, 8'h01, 8'h02, 8'h55};
      put_frame(fb, 11, 1'b0);

      phase_timeout = '{16'hFFFF, 16'd0, 16'($urandom_range(20, 65534)), 16'd1, TIMEOUT_RESET};
      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         write_timeout(phase_timeout[phase]);
         stall_on <= (phase != 4);
         while (bytes_sent < 24 + 290 * (phase + 1))
            random_chunk(phase == 4);
      end

      wait_drained();
      repeat (6) @(negedge clock);
      $display("Sent %0d bytes under %0d timeout settings; %0d result words checked.",
               bytes_sent, settings, frames_checked);
      $display("Frames of every type, bad checksums, header restarts and timeouts included.");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
